/* rtl/rpnfa_pkg.sv */
// ----------------------------------------------------------------------------
// rpnfa_pkg
// Shared constants and types for the postfix regex to NFA builder.
// ----------------------------------------------------------------------------
package rpnfa_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int STATE_BITS  = 8;
  localparam int DEPTH_BITS  = $clog2(STACK_DEPTH);
  localparam int CNT_BITS    = DEPTH_BITS + 1;
  localparam int NUM_BITS    = STATE_BITS + 1;
  localparam int FIELD_W     = 8;
  localparam int MAX_MOVES   = 4;
  localparam int STEP_BITS   = $clog2(MAX_MOVES);

  // highest state counter value that still leaves two fresh numbers
  localparam logic [NUM_BITS-1:0] NUM_LIMIT_M2 = NUM_BITS'((1 << STATE_BITS) - 2);

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CAT    = 8'h2E;
  localparam logic [7:0] CH_ALT    = 8'h7C;
  localparam logic [7:0] EPS_RESET = 8'h65;

  typedef logic [STATE_BITS-1:0] state_num_t;

  typedef struct packed {
    state_num_t start;
    state_num_t fin;
  } frag_t;

  typedef struct packed {
    state_num_t src;
    state_num_t dst;
  } move_t;

  typedef enum logic [2:0] {
    KIND_TRANS     = 3'd0,
    KIND_RESULT    = 3'd1,
    KIND_UNDERFLOW = 3'd2,
    KIND_STACK_OVF = 3'd3,
    KIND_STATE_OVF = 3'd4,
    KIND_BAD_FIN   = 3'd5
  } kind_t;

  // everything the output sequencer needs to play back one item's results
  typedef struct packed {
    kind_t                         kind;
    logic [FIELD_W-1:0]            label;
    logic                          eps;
    logic [STEP_BITS-1:0]          last_idx;
    move_t [MAX_MOVES-1:0]         moves;
  } item_desc_t;

endpackage

/* rtl/regex_postfix_to_nfa_builder.sv */
// ----------------------------------------------------------------------------
// regex_postfix_to_nfa_builder
// Thompson construction of an NFA from a postfix regex, one character per
// transfer, emitting transitions, a start/final report or an error code.
// ----------------------------------------------------------------------------
// Path: the first result of an item goes from the descriptor register to the
// output register before it is on m_axis.
// Flow: an item holds the input until all its results (1, or 4 for '|' and
// '*') reach the output register; '.' also stalls it for the stack read that
// refills the cached second fragment ('|' hides that read behind its four results).
// Reset: stack count and state counter go to zero, epsilon label to 'e';
// the stack memory is not cleared (entries are always written before they are used).
// ----------------------------------------------------------------------------
module regex_postfix_to_nfa_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [0:0]  s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] from_state, [15:8] label, [23:16] to_state
  output logic [3:0]  m_axis_tuser,   // [2:0] kind, [3] is_epsilon
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // epsilon_label
);
  import rpnfa_pkg::*;

  // --------------------------------------------------------------------------
  // Architectural state. The fragment stack lives in a one-port-write,
  // one-port-read memory. The top two fragments are also cached in flops so
  // an operator sees both operands at transfer time; the memory is written
  // through on every change so deeper entries are always current.
  // --------------------------------------------------------------------------
  logic [7:0]          epsilon_label;
  logic [CNT_BITS-1:0] stack_count;
  logic [NUM_BITS-1:0] next_num;
  frag_t               top;
  frag_t               second;
  logic                refill;      // second is being reloaded from memory

  frag_t               stack_mem [STACK_DEPTH];
  frag_t               rd_data;
  logic                wr_en;
  logic [DEPTH_BITS-1:0] wr_addr;
  frag_t               wr_data;
  logic [DEPTH_BITS-1:0] rd_addr;

  // next values from the decode of the offered item
  logic [CNT_BITS-1:0] count_next;
  logic [NUM_BITS-1:0] num_next;
  frag_t               top_next;
  frag_t               second_next;
  logic                pop;
  item_desc_t          desc_next;

  // output sequencer
  item_desc_t           desc;
  logic                 desc_valid;
  logic [STEP_BITS-1:0] step;
  logic                 out_load;
  logic                 desc_done;
  logic                 in_acc;

  logic [CNT_BITS-1:0]  cnt_m1;
  logic [CNT_BITS-1:0]  cnt_m2;
  logic [CNT_BITS-1:0]  cnt_m3;
  state_num_t           s_num;
  state_num_t           e_num;
  logic                 num_short;
  logic                 action;
  logic [7:0]           ch;

  assign action = s_axis_tuser[0];
  assign ch     = s_axis_tdata;

  assign cnt_m1 = stack_count - CNT_BITS'(1);
  assign cnt_m2 = stack_count - CNT_BITS'(2);
  assign cnt_m3 = stack_count - CNT_BITS'(3);

  // fresh state pair for literal, union and star
  assign s_num     = next_num[STATE_BITS-1:0];
  assign e_num     = s_num + STATE_BITS'(1);
  assign num_short = next_num > NUM_LIMIT_M2;

  // the entry that becomes second after a pop; read every cycle, used only
  // in the refill cycle after a '.' or '|'
  assign rd_addr = cnt_m3[DEPTH_BITS-1:0];

  // --------------------------------------------------------------------------
  // Item decode: builds the result descriptor and the new stack state.
  // --------------------------------------------------------------------------
  always_comb begin
    desc_next          = '0;
    desc_next.kind     = KIND_TRANS;
    desc_next.label    = epsilon_label;
    desc_next.eps      = 1'b1;
    desc_next.last_idx = '0;
    count_next         = stack_count;
    num_next           = next_num;
    top_next           = top;
    second_next        = second;
    pop                = 1'b0;
    wr_en              = 1'b0;
    wr_addr            = stack_count[DEPTH_BITS-1:0];
    wr_data            = top;

    if (action) begin
      // finish: report and clear, good or bad
      desc_next.label = '0;
      desc_next.eps   = 1'b0;
      if (stack_count == CNT_BITS'(1)) begin
        desc_next.kind         = KIND_RESULT;
        desc_next.moves[0].src = top.start;
        desc_next.moves[0].dst = top.fin;
      end else begin
        desc_next.kind = KIND_BAD_FIN;
      end
      count_next = '0;
      num_next   = '0;
    end else if (ch == CH_CAT) begin
      if (stack_count < CNT_BITS'(2)) begin
        desc_next.kind  = KIND_UNDERFLOW;
        desc_next.label = '0;
        desc_next.eps   = 1'b0;
      end else begin
        desc_next.moves[0].src = second.fin;
        desc_next.moves[0].dst = top.start;
        top_next.start = second.start;
        top_next.fin   = top.fin;
        count_next     = cnt_m1;
        pop            = 1'b1;
        wr_en          = 1'b1;
        wr_addr        = cnt_m2[DEPTH_BITS-1:0];
        wr_data        = top_next;
      end
    end else if (ch == CH_ALT || ch == CH_STAR) begin
      if ((ch == CH_ALT && stack_count < CNT_BITS'(2)) ||
          (ch == CH_STAR && stack_count == '0)) begin
        desc_next.kind  = KIND_UNDERFLOW;
        desc_next.label = '0;
        desc_next.eps   = 1'b0;
      end else if (num_short) begin
        desc_next.kind  = KIND_STATE_OVF;
        desc_next.label = '0;
        desc_next.eps   = 1'b0;
      end else begin
        desc_next.last_idx = STEP_BITS'(MAX_MOVES - 1);
        num_next           = next_num + NUM_BITS'(2);
        top_next.start     = s_num;
        top_next.fin       = e_num;
        wr_en              = 1'b1;
        wr_data            = top_next;
        if (ch == CH_ALT) begin
          desc_next.moves[0] = '{src: s_num,      dst: second.start};
          desc_next.moves[1] = '{src: s_num,      dst: top.start};
          desc_next.moves[2] = '{src: second.fin, dst: e_num};
          desc_next.moves[3] = '{src: top.fin,    dst: e_num};
          count_next = cnt_m1;
          pop        = 1'b1;
          wr_addr    = cnt_m2[DEPTH_BITS-1:0];
        end else begin
          desc_next.moves[0] = '{src: s_num,   dst: top.start};
          desc_next.moves[1] = '{src: s_num,   dst: e_num};
          desc_next.moves[2] = '{src: top.fin, dst: top.start};
          desc_next.moves[3] = '{src: top.fin, dst: e_num};
          wr_addr = cnt_m1[DEPTH_BITS-1:0];
        end
      end
    end else begin
      // literal
      desc_next.label = ch;
      desc_next.eps   = 1'b0;
      if (stack_count >= CNT_BITS'(STACK_DEPTH)) begin
        desc_next.kind  = KIND_STACK_OVF;
        desc_next.label = '0;
      end else if (num_short) begin
        desc_next.kind  = KIND_STATE_OVF;
        desc_next.label = '0;
      end else begin
        desc_next.moves[0] = '{src: s_num, dst: e_num};
        num_next       = next_num + NUM_BITS'(2);
        second_next    = top;
        top_next.start = s_num;
        top_next.fin   = e_num;
        count_next     = stack_count + CNT_BITS'(1);
        wr_en          = 1'b1;
        wr_addr        = stack_count[DEPTH_BITS-1:0];
        wr_data        = top_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Handshakes. A new item is taken whenever the sequencer is empty or hands
  // its last result to the output register in this cycle, except during the
  // one-cycle stack refill.
  // --------------------------------------------------------------------------
  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign desc_done     = desc_valid && out_load && (step == desc.last_idx);
  assign s_axis_tready = !refill && (!desc_valid || desc_done);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // stack memory: write-through from decode, registered read
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data <= stack_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon_label <= EPS_RESET;
      stack_count   <= '0;
      next_num      <= '0;
      refill        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        epsilon_label <= cfg_data;
      end
      refill <= in_acc && pop;
      if (in_acc) begin
        stack_count <= count_next;
        next_num    <= num_next;
      end
    end
  end

  // cached top two fragments
  always_ff @(posedge clk) begin
    if (in_acc) begin
      top    <= top_next;
      second <= second_next;
    end else if (refill) begin
      second <= rd_data;
    end
  end

  // --------------------------------------------------------------------------
  // Output sequencer: plays one result per cycle into the output register while that register is free or being drained.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      step       <= '0;
    end else if (in_acc) begin
      desc_valid <= 1'b1;
      step       <= '0;
    end else if (desc_done) begin
      desc_valid <= 1'b0;
    end else if (desc_valid && out_load) begin
      step <= step + STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      desc <= desc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (desc_valid && out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && out_load) begin
      m_axis_tdata <= {FIELD_W'(desc.moves[step].dst), desc.label,
                       FIELD_W'(desc.moves[step].src)};
      m_axis_tuser <= {desc.eps, desc.kind};
      m_axis_tlast <= (step == desc.last_idx);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // no item may be decoded while the cached second fragment is stale
  a_refill_blocks: assert property (@(posedge clk) disable iff (rst)
    refill |-> !s_axis_tready)
    else $error("item taken during stack refill");

  // a finish clears the stack and the state counter
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && action) |=> (stack_count == '0 && next_num == '0))
    else $error("finish did not clear the builder");

  // state numbers are handed out in pairs and never pass the limit
  a_num_pairs: assert property (@(posedge clk) disable iff (rst)
    !next_num[0] && (next_num <= NUM_LIMIT_M2 + NUM_BITS'(2)))
    else $error("state counter out of range");

  // stack never grows beyond its depth
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_BITS'(STACK_DEPTH))
    else $error("stack count beyond depth");

endmodule
